@@ hw/rtl/bpa_pkg.sv @@
// Shared types, constants and helpers for the buddy page allocator.
// Used by bpa_bitmap and buddy_page_allocator; depends on nothing else.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int PAGE_BITS   = 12;
  localparam int ORDER_COUNT = 11;
  localparam int ORDER_BITS  = 4;
  localparam int REF_BITS    = 16;
  localparam int FLAG_BITS   = 8;
  localparam int WORD_LOG    = 6;
  localparam int WORD_BITS   = 1 << WORD_LOG;
  localparam int WIDX_BITS   = PAGE_BITS - WORD_LOG;
  localparam int BM_DEPTH    = ORDER_COUNT << WIDX_BITS;
  localparam int BM_ABITS    = ORDER_BITS + WIDX_BITS;
  localparam int PAGES       = 1 << PAGE_BITS;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_MARK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_TOO_BIG = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [PAGE_BITS-1:0] page_index;
    logic [3:0]           size_order;
    logic [FLAG_BITS-1:0] alloc_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PAGE_BITS-1:0] block_page;
    logic [REF_BITS-1:0]  ref_count;
  } rsp_t;

  // Command from the sequencer to the bitmap store.
  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [ORDER_BITS-1:0] order;
    logic [WIDX_BITS-1:0]  word;
    logic [WORD_BITS-1:0]  wr_data;
    logic [ORDER_BITS-1:0] min_order;
  } bm_cmd_t;

  // Read data and lowest-free-word search result from the bitmap store.
  typedef struct packed {
    logic [WORD_BITS-1:0]  rd_data;
    logic                  hit;
    logic [ORDER_BITS-1:0] hit_order;
    logic [WIDX_BITS-1:0]  hit_word;
  } bm_rsp_t;

  // Index of the lowest set bit of a word; zero when the word is empty.
  function automatic logic [WORD_LOG-1:0] lsb_idx(input logic [WORD_BITS-1:0] v);
    logic [WORD_LOG-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = WORD_LOG'(i);
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/buddy_page_allocator.sv @@
// Buddy page allocator top level: request sequencer and the per-page
// reference count and flag memories. Depends on bpa_pkg and bpa_bitmap.
`timescale 1ns / 1ps
// Usage: a request (allocate, free or mark) is presented on req with start
// high; it is taken at a rising edge where start is high and busy is low.
// Exactly one response follows on rsp, marked by done for a single cycle.
// The receiver cannot stall; done is simply a strobe and must be sampled.
//
// After acceptance, mark reads the page count and writes it back one higher,
// saturating; free reads the count and, when it is one, walks the bitmap up
// through each buddy merge; allocate searches the bitmap, takes a block,
// makes its splits (at most 10) and writes the head, or reports no free
// block. Bad orders and unknown requests answer from idle. Each order
// walked is one read and one write of the bitmap memory, which has a single
// port and a registered read, so the bitmap walk sets the rate. Busy drops
// in the cycle done is shown, so the next request can be taken while the response is on the ports.
//
// After reset the block runs a clearing pass that writes a reference
// count of one and zero flags to each of the 4096 pages; busy is high during
// it. The free bitmap starts empty through its summary flip-flops, so no
// page is free until software frees pages into the pool.
module buddy_page_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bpa_pkg::req_t req,
  output logic          done,
  output bpa_pkg::rsp_t rsp
);

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_FREF  = 13'b0000000000100,
    S_FCHK  = 13'b0000000001000,
    S_MRD   = 13'b0000000010000,
    S_MWR   = 13'b0000000100000,
    S_KREF  = 13'b0000001000000,
    S_KCHK  = 13'b0000010000000,
    S_AFIND = 13'b0000100000000,
    S_ATAKE = 13'b0001000000000,
    S_SRD   = 13'b0010000000000,
    S_SWR   = 13'b0100000000000,
    S_AHEAD = 13'b1000000000000
  } state_t;

  localparam logic [bpa_pkg::REF_BITS-1:0] REF_MAX = '1;
  localparam logic [bpa_pkg::REF_BITS-1:0] REF_ONE = bpa_pkg::REF_BITS'(1);
  localparam logic [bpa_pkg::ORDER_BITS-1:0] TOP_ORDER =
    bpa_pkg::ORDER_BITS'(bpa_pkg::ORDER_COUNT - 1);
  localparam bpa_pkg::rsp_t RSP_TOO_BIG =
    {bpa_pkg::ST_TOO_BIG, {(bpa_pkg::PAGE_BITS + bpa_pkg::REF_BITS){1'b0}}};

  state_t state;
  logic [bpa_pkg::PAGE_BITS-1:0]  clr_cnt;
  bpa_pkg::req_t                  cur;
  logic [bpa_pkg::ORDER_BITS-1:0] k;
  logic [bpa_pkg::PAGE_BITS-1:0]  b;
  logic [bpa_pkg::PAGE_BITS-1:0]  head;

  // Page memories: reference count and flags share one address.
  logic [bpa_pkg::REF_BITS-1:0]  ref_mem [0:bpa_pkg::PAGES-1];
  logic [bpa_pkg::FLAG_BITS-1:0] flg_mem [0:bpa_pkg::PAGES-1];
  logic [bpa_pkg::REF_BITS-1:0]  ref_q;
  logic [bpa_pkg::PAGE_BITS-1:0] pg_addr;
  logic                          ref_we;
  logic [bpa_pkg::REF_BITS-1:0]  ref_wd;
  logic                          flg_we;
  logic [bpa_pkg::FLAG_BITS-1:0] flg_wd;

  bpa_pkg::bm_cmd_t bm_cmd;
  bpa_pkg::bm_rsp_t bm_rsp;

  // Working values derived from the walk registers.
  logic [bpa_pkg::WORD_LOG-1:0]  take_bit;
  logic [bpa_pkg::PAGE_BITS-1:0] take_b;
  logic [bpa_pkg::PAGE_BITS-1:0] split_b;
  logic [bpa_pkg::PAGE_BITS-1:0] bud_b;
  logic                          bud_free;
  logic                          accept;

  bpa_bitmap u_bitmap (
    .clk (clk),
    .rst (rst),
    .cmd (bm_cmd),
    .rsp (bm_rsp)
  );

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[pg_addr] <= ref_wd;
    end
    if (flg_we) begin
      flg_mem[pg_addr] <= flg_wd;
    end
    ref_q <= ref_mem[pg_addr];
  end

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign take_bit = bpa_pkg::lsb_idx(bm_rsp.rd_data);
  assign take_b   = {b[bpa_pkg::PAGE_BITS-1:bpa_pkg::WORD_LOG], take_bit};
  assign split_b  = {b[bpa_pkg::PAGE_BITS-1:1], 1'b1};
  assign bud_b    = {b[bpa_pkg::PAGE_BITS-1:1], ~b[0]};
  assign bud_free = (k < TOP_ORDER) && bm_rsp.rd_data[bud_b[bpa_pkg::WORD_LOG-1:0]];

  // Memory port control for each step of the sequencer.
  always_comb begin
    bm_cmd           = '0;
    bm_cmd.order     = k;
    bm_cmd.word      = b[bpa_pkg::PAGE_BITS-1:bpa_pkg::WORD_LOG];
    bm_cmd.min_order = cur.size_order;
    pg_addr          = head;
    ref_we           = 1'b0;
    ref_wd           = '0;
    flg_we           = 1'b0;
    flg_wd           = '0;
    case (state)
      S_CLR: begin
        pg_addr = clr_cnt;
        ref_we  = 1'b1;
        ref_wd  = REF_ONE;
        flg_we  = 1'b1;
      end
      S_FCHK: begin
        if (ref_q > REF_ONE) begin
          ref_we = 1'b1;
          ref_wd = ref_q - REF_ONE;
        end
      end
      S_KCHK: begin
        if (ref_q != REF_MAX) begin
          ref_we = 1'b1;
          ref_wd = ref_q + REF_ONE;
        end
      end
      S_MRD: begin
        bm_cmd.rd_en = 1'b1;
      end
      S_MWR: begin
        bm_cmd.wr_en = 1'b1;
        ref_we       = 1'b1;
        if (bud_free) begin
          // Absorb the free buddy: its head page becomes an inner page.
          bm_cmd.wr_data = bm_rsp.rd_data &
                           ~(bpa_pkg::WORD_BITS'(1) << bud_b[bpa_pkg::WORD_LOG-1:0]);
          pg_addr        = bud_b << k;
          ref_wd         = REF_ONE;
        end else begin
          bm_cmd.wr_data = bm_rsp.rd_data |
                           (bpa_pkg::WORD_BITS'(1) << b[bpa_pkg::WORD_LOG-1:0]);
          pg_addr        = b << k;
          flg_we         = 1'b1;
        end
      end
      S_AFIND: begin
        bm_cmd.rd_en = bm_rsp.hit;
        bm_cmd.order = bm_rsp.hit_order;
        bm_cmd.word  = bm_rsp.hit_word;
      end
      S_ATAKE: begin
        bm_cmd.wr_en   = 1'b1;
        bm_cmd.wr_data = bm_rsp.rd_data & ~(bpa_pkg::WORD_BITS'(1) << take_bit);
      end
      S_SRD: begin
        bm_cmd.rd_en = 1'b1;
      end
      S_SWR: begin
        // The upper half of the split block goes free.
        bm_cmd.wr_en   = 1'b1;
        bm_cmd.wr_data = bm_rsp.rd_data |
                         (bpa_pkg::WORD_BITS'(1) << split_b[bpa_pkg::WORD_LOG-1:0]);
        pg_addr        = split_b << k;
        ref_we         = 1'b1;
        flg_we         = 1'b1;
      end
      S_AHEAD: begin
        pg_addr = b << k;
        ref_we  = 1'b1;
        ref_wd  = REF_ONE;
        flg_we  = 1'b1;
        flg_wd  = cur.alloc_flags;
      end
      default: begin
      end
    endcase
  end

  // Every arm drives done exactly once, so the strobe lasts one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          done    <= 1'b0;
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur <= req;
            k   <= req.size_order;
            b   <= req.page_index >> req.size_order;
            case (req.req_type)
              bpa_pkg::REQ_ALLOC, bpa_pkg::REQ_FREE: begin
                head <= (req.page_index >> req.size_order) << req.size_order;
                if (req.size_order >= bpa_pkg::ORDER_BITS'(bpa_pkg::ORDER_COUNT)) begin
                  rsp  <= RSP_TOO_BIG;
                  done <= 1'b1;
                end else if (req.req_type == bpa_pkg::REQ_ALLOC) begin
                  rsp   <= '0;
                  done  <= 1'b0;
                  state <= S_AFIND;
                end else begin
                  rsp   <= '0;
                  done  <= 1'b0;
                  state <= S_FREF;
                end
              end
              bpa_pkg::REQ_MARK: begin
                head  <= req.page_index;
                rsp   <= '0;
                done  <= 1'b0;
                state <= S_KREF;
              end
              default: begin
                rsp  <= '0;
                done <= 1'b1;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_FREF: begin
          done  <= 1'b0;
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (ref_q == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (ref_q > REF_ONE) begin
            rsp.ref_count <= ref_q - REF_ONE;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            done  <= 1'b0;
            state <= S_MRD;
          end
        end
        S_MRD: begin
          done  <= 1'b0;
          state <= S_MWR;
        end
        S_MWR: begin
          if (bud_free) begin
            b     <= b >> 1;
            k     <= k + 1'b1;
            done  <= 1'b0;
            state <= S_MRD;
          end else begin
            // The freed head page reads zero unless it was merged into a
            // larger block as an upper part, where it keeps its one.
            rsp.ref_count <= (head == (b << k)) ? '0 : REF_ONE;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_KREF: begin
          done  <= 1'b0;
          state <= S_KCHK;
        end
        S_KCHK: begin
          rsp.ref_count <= (ref_q != REF_MAX) ? ref_q + REF_ONE : ref_q;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_AFIND: begin
          if (bm_rsp.hit) begin
            k     <= bm_rsp.hit_order;
            b     <= {bm_rsp.hit_word, bpa_pkg::WORD_LOG'(0)};
            done  <= 1'b0;
            state <= S_ATAKE;
          end else begin
            rsp.status <= bpa_pkg::ST_NO_FREE;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_ATAKE: begin
          done <= 1'b0;
          if (k == cur.size_order) begin
            b     <= take_b;
            state <= S_AHEAD;
          end else begin
            b     <= {take_b[bpa_pkg::PAGE_BITS-2:0], 1'b0};
            k     <= k - 1'b1;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          done  <= 1'b0;
          state <= S_SWR;
        end
        S_SWR: begin
          done <= 1'b0;
          if (k == cur.size_order) begin
            state <= S_AHEAD;
          end else begin
            b     <= {b[bpa_pkg::PAGE_BITS-2:0], 1'b0};
            k     <= k - 1'b1;
            state <= S_SRD;
          end
        end
        S_AHEAD: begin
          rsp.block_page <= b << k;
          rsp.ref_count  <= REF_ONE;
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/bpa_bitmap.sv @@
// Free-block bitmap store: one 64-bit word memory for all orders plus a
// flip-flop summary bit per word. Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_bitmap (
  input  logic             clk,
  input  logic             rst,
  input  bpa_pkg::bm_cmd_t cmd,
  output bpa_pkg::bm_rsp_t rsp
);

  logic [bpa_pkg::WORD_BITS-1:0] mem [0:bpa_pkg::BM_DEPTH-1];
  logic [bpa_pkg::WORD_BITS-1:0] sum_q [0:bpa_pkg::ORDER_COUNT-1];
  logic [bpa_pkg::WORD_BITS-1:0] rd_q;
  logic                          rd_vld;
  logic [bpa_pkg::BM_ABITS-1:0]  addr;
  logic [bpa_pkg::ORDER_BITS-1:0] hit_order;
  logic                          hit;

  assign addr = {cmd.order, cmd.word};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[addr];
    end
  end

  // A word whose summary bit is clear has never held a free bit since
  // reset, or holds none now, so its memory content is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bpa_pkg::ORDER_COUNT; k++) begin
        sum_q[k] <= '0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        sum_q[cmd.order][cmd.word] <= |cmd.wr_data;
      end
      if (cmd.rd_en) begin
        rd_vld <= sum_q[cmd.order][cmd.word];
      end
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_order = '0;
    for (int k = bpa_pkg::ORDER_COUNT - 1; k >= 0; k--) begin
      if ((|sum_q[k]) && (bpa_pkg::ORDER_BITS'(k) >= cmd.min_order)) begin
        hit       = 1'b1;
        hit_order = bpa_pkg::ORDER_BITS'(k);
      end
    end
  end

  assign rsp.rd_data   = rd_q & {bpa_pkg::WORD_BITS{rd_vld}};
  assign rsp.hit       = hit;
  assign rsp.hit_order = hit_order;
  assign rsp.hit_word  = bpa_pkg::lsb_idx(sum_q[hit_order]);

endmodule

@@ sim/buddy_page_allocator_tb.sv @@
// Self-checking testbench for the buddy page allocator: directed and random requests.
// Depends on bpa_pkg and the buddy_page_allocator RTL; its own predictor checks every response.
`timescale 1ns / 1ps
module buddy_page_allocator_tb;

  localparam int IDLE_LIMIT = 20000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  logic           done;
  bpa_pkg::req_t  req = '0;
  bpa_pkg::rsp_t  rsp;

  buddy_page_allocator dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator: one free bit per block per order, plus the
  // per-page reference counts and flags.
  bit                               free_map [bpa_pkg::ORDER_COUNT][bpa_pkg::PAGES];
  logic [bpa_pkg::REF_BITS-1:0]     page_refs [bpa_pkg::PAGES];
  logic [bpa_pkg::FLAG_BITS-1:0]    page_flags [bpa_pkg::PAGES];

  bpa_pkg::rsp_t pending_rsp[$];
  int   errors = 0;
  int   idle_cycles = 0;

  // Blocks handed out by the allocator that the random part may free or mark.
  typedef struct {
    logic [bpa_pkg::PAGE_BITS-1:0] head;
    int                            ord;
  } blk_t;
  blk_t live_blocks[$];

  function automatic bpa_pkg::rsp_t predict_request(bpa_pkg::req_t r);
    bpa_pkg::rsp_t                res;
    int                           o, k, b, n, blk, head;
    logic [bpa_pkg::REF_BITS-1:0] cnt;
    bit                           found;
    res = '0;
    o = int'(r.size_order);
    if (r.req_type == bpa_pkg::REQ_ALLOC || r.req_type == bpa_pkg::REQ_FREE) begin
      if (o >= bpa_pkg::ORDER_COUNT) begin
        res.status = bpa_pkg::ST_TOO_BIG;
        return res;
      end
    end
    case (r.req_type)
      bpa_pkg::REQ_ALLOC: begin
        found = 0;
        for (k = o; k < bpa_pkg::ORDER_COUNT && !found; k++) begin
          n = bpa_pkg::PAGES >> k;
          for (b = 0; b < n; b++) begin
            if (free_map[k][b]) begin
              found = 1;
              break;
            end
          end
          if (found) break;
        end
        if (!found) begin
          res.status = bpa_pkg::ST_NO_FREE;
          return res;
        end
        free_map[k][b] = 0;
        // Split down to the asked order, returning each upper half.
        while (k > o) begin
          k--;
          b = b << 1;
          free_map[k][b + 1] = 1;
          page_refs[(b + 1) << k]  = '0;
          page_flags[(b + 1) << k] = '0;
        end
        head = b << o;
        page_refs[head]  = bpa_pkg::REF_BITS'(1);
        page_flags[head] = r.alloc_flags;
        res.block_page = bpa_pkg::PAGE_BITS'(head);
        res.ref_count  = bpa_pkg::REF_BITS'(1);
      end
      bpa_pkg::REQ_FREE: begin
        blk = int'(r.page_index) >> o;
        head = blk << o;
        cnt = page_refs[head];
        if (cnt == '0) return res;
        if (cnt > bpa_pkg::REF_BITS'(1)) begin
          page_refs[head] = cnt - bpa_pkg::REF_BITS'(1);
          res.ref_count = cnt - bpa_pkg::REF_BITS'(1);
          return res;
        end
        k = o;
        b = blk;
        // Merge with free buddies upward as long as they are free.
        forever begin
          if (k + 1 < bpa_pkg::ORDER_COUNT && free_map[k][b ^ 1]) begin
            free_map[k][b ^ 1] = 0;
            page_refs[(b ^ 1) << k] = bpa_pkg::REF_BITS'(1);
            b = b >> 1;
            k++;
          end else begin
            free_map[k][b] = 1;
            page_refs[b << k]  = '0;
            page_flags[b << k] = '0;
            break;
          end
        end
        res.ref_count = page_refs[head];
      end
      bpa_pkg::REQ_MARK: begin
        if (page_refs[r.page_index] != '1)
          page_refs[r.page_index] = page_refs[r.page_index] + bpa_pkg::REF_BITS'(1);
        res.ref_count = page_refs[r.page_index];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Response checker: the receiver cannot stall, so every done strobe is a response.
  always @(posedge clk) begin
    bpa_pkg::rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response, status", rsp.status, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status != want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.block_page != want.block_page)
          report_mismatch("block_page", rsp.block_page, want.block_page);
        if (rsp.ref_count != want.ref_count)
          report_mismatch("ref_count", rsp.ref_count, want.ref_count);
      end
    end
  end

  // Watchdog: ends the run after too many cycles with neither a request taken
  // nor a response shown. The clearing pass after reset fits well inside it.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("buddy_page_allocator: mismatch");
        $finish;
      end
    end
  end

  // Presents one request and waits for the edge that takes it. Start stays
  // high afterwards so back-to-back requests need no second assignment.
  task automatic send_request(logic [1:0] kind, int page, int ord, int flags);
    bpa_pkg::req_t r;
    bpa_pkg::rsp_t want;
    r.req_type    = kind;
    r.page_index  = page[bpa_pkg::PAGE_BITS-1:0];
    r.size_order  = ord[3:0];
    r.alloc_flags = flags[bpa_pkg::FLAG_BITS-1:0];
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    want = predict_request(r);
    pending_rsp.push_back(want);
    if (kind == bpa_pkg::REQ_ALLOC && want.status == bpa_pkg::ST_OK)
      live_blocks.push_back('{want.block_page, ord});
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly short gaps, sometimes none at all, and now and then a long one.
  task automatic random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return;
    else if (pick < 92) pause_sender($urandom_range(1, 4));
    else pause_sender($urandom_range(10, 40));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_pool();
    // Nothing is free after reset, so every fitting allocate fails.
    send_request(bpa_pkg::REQ_ALLOC, 0, 0, 8'hFF);
    send_request(bpa_pkg::REQ_ALLOC, 0, 10, 0);
    send_request(bpa_pkg::REQ_ALLOC, 0, 11, 0);
    send_request(bpa_pkg::REQ_FREE, 4095, 15, 0);
    send_request(bpa_pkg::REQ_NONE, 12'hFFF, 4'hF, 8'hFF);
    drain();
  endtask

  task automatic test_fill_pool();
    // Freeing the four largest blocks fills the whole pool.
    for (int i = 0; i < 4; i++) begin
      send_request(bpa_pkg::REQ_FREE, i * 1024, 10, 0);
      random_gap();
    end
    drain();
  endtask

  task automatic test_directed_ops();
    send_request(bpa_pkg::REQ_ALLOC, 0, 0, 8'hA5);
    send_request(bpa_pkg::REQ_ALLOC, 0, 3, 8'h5A);
    send_request(bpa_pkg::REQ_ALLOC, 0, 10, 8'h01);
    send_request(bpa_pkg::REQ_MARK, 0, 0, 0);
    send_request(bpa_pkg::REQ_FREE, 0, 0, 0);
    send_request(bpa_pkg::REQ_FREE, 0, 0, 0);
    // Freeing a page that is already free is ignored.
    send_request(bpa_pkg::REQ_FREE, 0, 0, 0);
    // Misaligned free of the order-3 block.
    send_request(bpa_pkg::REQ_FREE, 13, 3, 0);
    send_request(bpa_pkg::REQ_MARK, 4095, 0, 0);
    send_request(bpa_pkg::REQ_MARK, 12'hFFF, 15, 8'hFF);
    live_blocks.delete();
    drain();
  endtask

  task automatic test_mark_count();
    // Raise one page's count well above one, then free it back past release.
    send_request(bpa_pkg::REQ_ALLOC, 0, 0, 8'h3C);
    for (int i = 0; i < 48; i++) send_request(bpa_pkg::REQ_MARK, 0, 0, 0);
    for (int i = 0; i < 50; i++) send_request(bpa_pkg::REQ_FREE, 0, 0, 0);
    live_blocks.delete();
    drain();
  endtask

  task automatic test_random(int count);
    int   pick, idx, ord;
    blk_t blk;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        ord = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(0, 15);
        send_request(bpa_pkg::REQ_ALLOC, $urandom_range(0, 4095), ord,
                     $urandom_range(0, 255));
      end else if (pick < 75 && live_blocks.size() != 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[idx];
        live_blocks.delete(idx);
        send_request(bpa_pkg::REQ_FREE, blk.head, blk.ord, $urandom_range(0, 255));
      end else if (pick < 85 && live_blocks.size() != 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        send_request(bpa_pkg::REQ_MARK, live_blocks[idx].head, $urandom_range(0, 15), 0);
      end else begin
        send_request(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
                     $urandom_range(0, 15), $urandom_range(0, 255));
      end
      random_gap();
      if (i % 400 == 399) drain();
    end
    drain();
  endtask

  task automatic test_free_inside_free();
    // Page 1 sits inside a free block as an absorbed upper buddy and reads
    // one reference, so freeing it makes the bitmaps overlap.
    while (live_blocks.size() != 0) begin
      send_request(bpa_pkg::REQ_FREE, live_blocks[0].head, live_blocks[0].ord, 0);
      void'(live_blocks.pop_front());
    end
    send_request(bpa_pkg::REQ_FREE, 1, 0, 0);
    send_request(bpa_pkg::REQ_ALLOC, 0, 0, 0);
    send_request(bpa_pkg::REQ_ALLOC, 0, 0, 0);
    drain();
  endtask

  initial begin
    for (int p = 0; p < bpa_pkg::PAGES; p++) begin
      page_refs[p]  = bpa_pkg::REF_BITS'(1);
      page_flags[p] = '0;
      for (int k = 0; k < bpa_pkg::ORDER_COUNT; k++) free_map[k][p] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_pool();
    test_fill_pool();
    test_directed_ops();
    test_mark_count();
    test_random(1450);
    test_free_inside_free();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("buddy_page_allocator: match");
    end else begin
      $display("buddy_page_allocator: mismatch");
    end
    $finish;
  end

endmodule
